// ===== sv/dppf_pkg.sv =====
// shared types, widths, register codes and reset values of the dual plane framebuffer
package dppf_pkg;

  // field widths
  localparam int COORD_W   = 10;
  localparam int SIZE_W    = 11;
  localparam int COLOR_W   = 16;
  localparam int RADDR_W   = 13;
  localparam int BYTE_W    = 8;
  localparam int BIT_IDX_W = 3;
  localparam int BPR_W     = 9;
  // row * bytes-per-row + column byte reaches 1023 * 256 + 255
  localparam int CALC_ADDR_W = 19;

  // configuration port
  localparam int PDATA_W   = 32;
  localparam int PADDR_W   = 5;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_LOGICAL_WIDTH  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_LOGICAL_HEIGHT = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_PHYSICAL_WIDTH = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ROTATED        = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_RED_CODE       = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_BLACK_CODE     = 3'd5;

  localparam logic [SIZE_W-1:0]  RST_LOGICAL_WIDTH  = 11'd176;
  localparam logic [SIZE_W-1:0]  RST_LOGICAL_HEIGHT = 11'd264;
  localparam logic [SIZE_W-1:0]  RST_PHYSICAL_WIDTH = 11'd176;
  localparam logic               RST_ROTATED        = 1'b0;
  localparam logic [COLOR_W-1:0] RST_RED_CODE       = 16'hF800;
  localparam logic [COLOR_W-1:0] RST_BLACK_CODE     = 16'h0000;

  // item codes
  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_READ   = 1'b1;
  localparam logic PLANE_BLACK = 1'b0;
  localparam logic PLANE_RED   = 1'b1;

  localparam int PLANE_BYTES_DEF = 8192;

  // msb-first pixel mask within a byte
  localparam logic [BYTE_W-1:0] PIX_MSB = 8'h80;

  typedef struct packed {
    logic [SIZE_W-1:0]  logical_width;
    logic [SIZE_W-1:0]  logical_height;
    logic [SIZE_W-1:0]  physical_width;
    logic               rotated;
    logic [COLOR_W-1:0] red_code;
    logic [COLOR_W-1:0] black_code;
  } cfg_t;

  // decoded request leaving the address unit
  typedef struct packed {
    logic                   mode;
    logic                   plane;
    logic                   is_red;
    logic                   is_black;
    logic                   oor;
    logic [BIT_IDX_W-1:0]   bit_idx;
    logic [CALC_ADDR_W-1:0] addr;
  } req_t;

  function automatic logic [BYTE_W-1:0] pix_mask(input logic [BIT_IDX_W-1:0] idx);
    pix_mask = PIX_MSB >> idx;
  endfunction

endpackage

// ===== sv/dppf_in_if.sv =====
// input channel: pixel write or byte read transaction
interface dppf_in_if
  import dppf_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               mode;
  logic [COORD_W-1:0] x;
  logic [COORD_W-1:0] y;
  logic [COLOR_W-1:0] color;
  logic               read_plane;
  logic [RADDR_W-1:0] read_address;

  modport source (output valid, mode, x, y, color, read_plane, read_address, input ready);
  modport sink (input valid, mode, x, y, color, read_plane, read_address, output ready);
endinterface

// ===== sv/dppf_out_if.sv =====
// result channel: read byte and range flag
interface dppf_out_if
  import dppf_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] read_data;
  logic              out_of_range;

  modport source (output valid, read_data, out_of_range, input ready);
  modport sink (input valid, read_data, out_of_range, output ready);
endinterface

// ===== sv/dppf_cfg.sv =====
// apb-style configuration register file
module dppf_cfg
  import dppf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  cfg_t                 cfg_r;
  cfg_t                 cfg_nxt;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = paddr[PADDR_W-1:2];

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_LOGICAL_WIDTH:  cfg_nxt.logical_width  = pwdata[SIZE_W-1:0];
        REG_LOGICAL_HEIGHT: cfg_nxt.logical_height = pwdata[SIZE_W-1:0];
        REG_PHYSICAL_WIDTH: cfg_nxt.physical_width = pwdata[SIZE_W-1:0];
        REG_ROTATED:        cfg_nxt.rotated        = pwdata[0];
        REG_RED_CODE:       cfg_nxt.red_code       = pwdata[COLOR_W-1:0];
        REG_BLACK_CODE:     cfg_nxt.black_code     = pwdata[COLOR_W-1:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.logical_width  <= RST_LOGICAL_WIDTH;
      cfg_r.logical_height <= RST_LOGICAL_HEIGHT;
      cfg_r.physical_width <= RST_PHYSICAL_WIDTH;
      cfg_r.rotated        <= RST_ROTATED;
      cfg_r.red_code       <= RST_RED_CODE;
      cfg_r.black_code     <= RST_BLACK_CODE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // register read mux
  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_LOGICAL_WIDTH:  prdata = PDATA_W'(cfg_r.logical_width);
      REG_LOGICAL_HEIGHT: prdata = PDATA_W'(cfg_r.logical_height);
      REG_PHYSICAL_WIDTH: prdata = PDATA_W'(cfg_r.physical_width);
      REG_ROTATED:        prdata = PDATA_W'(cfg_r.rotated);
      REG_RED_CODE:       prdata = PDATA_W'(cfg_r.red_code);
      REG_BLACK_CODE:     prdata = PDATA_W'(cfg_r.black_code);
      default:            prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ===== sv/dppf_addr.sv =====
// two-stage address unit: clamp and axis mapping, then byte address and range check
module dppf_addr
  import dppf_pkg::*;
#(
  parameter int PLANE_BYTES = PLANE_BYTES_DEF
) (
  input  logic               clk,
  input  cfg_t               cfg,
  input  logic               load1,
  input  logic               load2,
  input  logic               mode,
  input  logic [COORD_W-1:0] x,
  input  logic [COORD_W-1:0] y,
  input  logic [COLOR_W-1:0] color,
  input  logic               read_plane,
  input  logic [RADDR_W-1:0] read_address,
  output req_t               req
);

  localparam logic [CALC_ADDR_W-1:0] STORE_LIM = CALC_ADDR_W'(PLANE_BYTES);

  // stage one registers
  logic               mode1_r;
  logic               plane1_r;
  logic               red1_r;
  logic               black1_r;
  logic [RADDR_W-1:0] raddr1_r;
  logic [SIZE_W-1:0]  col1_r;
  logic [COORD_W-1:0] row1_r;

  logic [SIZE_W-1:0]  wlim;
  logic [SIZE_W-1:0]  hlim;
  logic [COORD_W-1:0] xc;
  logic [COORD_W-1:0] yc;
  logic [SIZE_W-1:0]  col1_nxt;
  logic [COORD_W-1:0] row1_nxt;

  // clamp limits, zero size clamps to zero
  assign wlim = (cfg.logical_width  != '0) ? cfg.logical_width  - 1'b1 : '0;
  assign hlim = (cfg.logical_height != '0) ? cfg.logical_height - 1'b1 : '0;
  assign xc   = ({1'b0, x} > wlim) ? wlim[COORD_W-1:0] : x;
  assign yc   = ({1'b0, y} > hlim) ? hlim[COORD_W-1:0] : y;

  // rotated mode swaps the axes and mirrors the column
  always_comb begin
    if (cfg.rotated) begin
      col1_nxt = hlim - {1'b0, yc};
      row1_nxt = xc;
    end else begin
      col1_nxt = {1'b0, xc};
      row1_nxt = yc;
    end
  end

  always_ff @(posedge clk) begin
    if (load1) begin
      mode1_r  <= mode;
      plane1_r <= read_plane;
      red1_r   <= (color == cfg.red_code);
      black1_r <= (color == cfg.black_code);
      raddr1_r <= read_address;
      col1_r   <= col1_nxt;
      row1_r   <= row1_nxt;
    end
  end

  // stage two: row * bytes-per-row + column byte
  logic [SIZE_W:0]           bpr_sum;
  logic [BPR_W-1:0]          bpr;
  logic [CALC_ADDR_W-1:0]    pix_addr;
  logic [CALC_ADDR_W-1:0]    addr2_nxt;
  req_t                      req_r;
  req_t                      req_nxt;

  assign bpr_sum  = {1'b0, cfg.physical_width} + (SIZE_W+1)'(7);
  assign bpr      = bpr_sum[SIZE_W:3];
  assign pix_addr = CALC_ADDR_W'(row1_r) * CALC_ADDR_W'(bpr)
                  + CALC_ADDR_W'(col1_r[SIZE_W-1:BIT_IDX_W]);
  assign addr2_nxt = (mode1_r == MODE_READ) ? CALC_ADDR_W'(raddr1_r) : pix_addr;

  always_comb begin
    req_nxt.mode     = mode1_r;
    req_nxt.plane    = plane1_r;
    req_nxt.is_red   = red1_r;
    req_nxt.is_black = black1_r;
    req_nxt.bit_idx  = col1_r[BIT_IDX_W-1:0];
    req_nxt.addr     = addr2_nxt;
    req_nxt.oor      = (addr2_nxt >= STORE_LIM);
  end

  always_ff @(posedge clk) begin
    if (load2) begin
      req_r <= req_nxt;
    end
  end

  assign req = req_r;

endmodule

// ===== sv/dppf_planes.sv =====
// black and red bit plane memories, one registered read port and one write port each
module dppf_planes
  import dppf_pkg::*;
#(
  parameter int PLANE_BYTES = PLANE_BYTES_DEF,
  parameter int AW          = $clog2(PLANE_BYTES)
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [BYTE_W-1:0] wr_black,
  input  logic [BYTE_W-1:0] wr_red,
  output logic [BYTE_W-1:0] black_q,
  output logic [BYTE_W-1:0] red_q
);

  logic [BYTE_W-1:0] black_mem [PLANE_BYTES];
  logic [BYTE_W-1:0] red_mem   [PLANE_BYTES];
  logic [BYTE_W-1:0] black_q_r;
  logic [BYTE_W-1:0] red_q_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      black_mem[wr_addr] <= wr_black;
      red_mem[wr_addr]   <= wr_red;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      black_q_r <= black_mem[rd_addr];
      red_q_r   <= red_mem[rd_addr];
    end
  end

  assign black_q = black_q_r;
  assign red_q   = red_q_r;

endmodule

// ===== sv/dual_plane_pixel_framebuffer.sv =====
// top level: address unit, plane memories, read-modify-write sequencing and output register
// an accepted transaction passes the two address stages, the memory read and the output register
// one transaction is in flight at a time: a new input is taken only after the
//   memory read-modify-write pass of the last one, and a waiting result that
//   is not taken holds off that pass and so the next input
// reset: rst_n synchronous, restores register defaults and clears control state;
//   plane contents are not cleared and stay undefined until written
module dual_plane_pixel_framebuffer
  import dppf_pkg::*;
#(
  parameter int PLANE_BYTES = PLANE_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  dppf_in_if.sink            in_ch,
  dppf_out_if.source         out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int AW = $clog2(PLANE_BYTES);

  cfg_t              cfg;
  req_t              req2;
  req_t              req3_r;
  logic              busy_r, busy_nxt;
  logic              v1_r, v2_r, v3_r;
  logic              v3_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_data_r;
  logic              out_oor_r;
  logic              accept;
  logic              fire3;
  logic              wr_en;
  logic [BYTE_W-1:0] black_q, red_q;
  logic [BYTE_W-1:0] black_new, red_new;
  logic [BYTE_W-1:0] mask;
  logic [BYTE_W-1:0] res_data;

  dppf_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dppf_addr #(.PLANE_BYTES(PLANE_BYTES)) u_addr (
    .clk          (clk),
    .cfg          (cfg),
    .load1        (accept),
    .load2        (v1_r),
    .mode         (in_ch.mode),
    .x            (in_ch.x),
    .y            (in_ch.y),
    .color        (in_ch.color),
    .read_plane   (in_ch.read_plane),
    .read_address (in_ch.read_address),
    .req          (req2)
  );

  dppf_planes #(.PLANE_BYTES(PLANE_BYTES), .AW(AW)) u_planes (
    .clk      (clk),
    .rd_en    (v2_r),
    .rd_addr  (req2.addr[AW-1:0]),
    .wr_en    (wr_en),
    .wr_addr  (req3_r.addr[AW-1:0]),
    .wr_black (black_new),
    .wr_red   (red_new),
    .black_q  (black_q),
    .red_q    (red_q)
  );

  // handshake and sequencing
  assign in_ch.ready = !busy_r;
  assign accept      = in_ch.valid && !busy_r;
  assign fire3       = v3_r && (!out_valid_r || out_ch.ready);

  assign busy_nxt      = accept ? 1'b1 : (fire3 ? 1'b0 : busy_r);
  assign v3_nxt        = v2_r ? 1'b1 : (fire3 ? 1'b0 : v3_r);
  assign out_valid_nxt = fire3 ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      v1_r        <= accept;
      v2_r        <= v1_r;
      v3_r        <= v3_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // request travels alongside the memory read
  always_ff @(posedge clk) begin
    if (v2_r) begin
      req3_r <= req2;
    end
  end

  // modify: set the chosen plane bit and clear the other, red first; no match clears both
  assign mask = pix_mask(req3_r.bit_idx);

  always_comb begin
    priority if (req3_r.is_red) begin
      red_new   = red_q | mask;
      black_new = black_q & ~mask;
    end else if (req3_r.is_black) begin
      black_new = black_q | mask;
      red_new   = red_q & ~mask;
    end else begin
      black_new = black_q & ~mask;
      red_new   = red_q & ~mask;
    end
  end

  assign wr_en = fire3 && (req3_r.mode == MODE_WRITE) && !req3_r.oor;

  // result byte: zero for pixel writes and out-of-range reads
  always_comb begin
    res_data = '0;
    if ((req3_r.mode == MODE_READ) && !req3_r.oor) begin
      res_data = (req3_r.plane == PLANE_RED) ? red_q : black_q;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (fire3) begin
      out_data_r <= res_data;
      out_oor_r  <= req3_r.oor;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.read_data    = out_data_r;
  assign out_ch.out_of_range = out_oor_r;

endmodule

// ===== test/tb.sv =====
// self-checking testbench for the dual plane pixel framebuffer
module tb;
  import dppf_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 800;
  localparam int CALM_ITEMS = 150;

  typedef struct packed {
    logic               mode;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COLOR_W-1:0] color;
    logic               read_plane;
    logic [RADDR_W-1:0] read_address;
  } fb_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] read_data;
    logic              out_of_range;
  } fb_result_t;

  logic clk;
  logic rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  dppf_in_if  in_if ();
  dppf_out_if out_if ();

  dual_plane_pixel_framebuffer dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_if),
    .out_ch  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // own copy of the planes, registers and which bits have been written
  logic [BYTE_W-1:0] black_mem   [PLANE_BYTES_DEF];
  logic [BYTE_W-1:0] red_mem     [PLANE_BYTES_DEF];
  logic [BYTE_W-1:0] filled_bits [PLANE_BYTES_DEF];
  int unsigned       complete_bytes[$];
  fb_result_t        expected_bytes[$];
  cfg_t              shadow_cfg;

  bit idle_on;
  int items_sent;
  int results_seen;
  int mismatches;
  int reads_sent;
  int oor_writes;
  int stall_cycles;

  // clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 40) $display("MISMATCH @%0t: %s", $time, what);
  endtask

  function automatic int unsigned clamp_limit(input int unsigned size);
    return (size != 0) ? size - 1 : 0;
  endfunction

  // logical coordinates to panel column and row
  function automatic void panel_pos(input int unsigned x, input int unsigned y,
                                    output int unsigned col, output int unsigned row);
    int unsigned lim_x;
    int unsigned lim_y;
    int unsigned cx;
    int unsigned cy;
    lim_x = clamp_limit(shadow_cfg.logical_width);
    lim_y = clamp_limit(shadow_cfg.logical_height);
    cx = (x > lim_x) ? lim_x : x;
    cy = (y > lim_y) ? lim_y : y;
    if (shadow_cfg.rotated) begin
      col = lim_y - cy;
      row = cx;
    end else begin
      col = cx;
      row = cy;
    end
  endfunction

  // apply one transaction to the plane copy and give the byte it returns
  function automatic fb_result_t plane_step(input fb_item_t it);
    int unsigned       col;
    int unsigned       row;
    int unsigned       bpr;
    int unsigned       addr;
    logic [BYTE_W-1:0] mask;
    fb_result_t        res;
    res.read_data    = '0;
    res.out_of_range = 1'b0;
    if (it.mode == MODE_READ) begin
      reads_sent++;
      if (it.read_address >= PLANE_BYTES_DEF) res.out_of_range = 1'b1;
      else if (it.read_plane == PLANE_RED) res.read_data = red_mem[it.read_address];
      else res.read_data = black_mem[it.read_address];
      return res;
    end
    panel_pos(it.x, it.y, col, row);
    bpr  = (shadow_cfg.physical_width + 7) / 8;
    addr = row * bpr + col / 8;
    mask = PIX_MSB >> (col % 8);
    if (addr >= PLANE_BYTES_DEF) begin
      oor_writes++;
      res.out_of_range = 1'b1;
      return res;
    end
    // red takes priority when both codes match
    if (it.color == shadow_cfg.red_code) begin
      red_mem[addr]   = red_mem[addr] | mask;
      black_mem[addr] = black_mem[addr] & ~mask;
    end else if (it.color == shadow_cfg.black_code) begin
      black_mem[addr] = black_mem[addr] | mask;
      red_mem[addr]   = red_mem[addr] & ~mask;
    end else begin
      black_mem[addr] = black_mem[addr] & ~mask;
      red_mem[addr]   = red_mem[addr] & ~mask;
    end
    if (filled_bits[addr] != 8'hFF) begin
      filled_bits[addr] = filled_bits[addr] | mask;
      if (filled_bits[addr] == 8'hFF) complete_bytes.push_back(addr);
    end
    return res;
  endfunction

  function automatic fb_item_t make_write(input int unsigned x, input int unsigned y,
                                          input logic [COLOR_W-1:0] colour);
    fb_item_t it;
    it.mode         = MODE_WRITE;
    it.x            = x[COORD_W-1:0];
    it.y            = y[COORD_W-1:0];
    it.color        = colour;
    it.read_plane   = 1'($urandom_range(0, 1));
    it.read_address = RADDR_W'($urandom_range(0, (1 << RADDR_W) - 1));
    return it;
  endfunction

  function automatic fb_item_t make_read(input logic plane, input int unsigned addr);
    fb_item_t it;
    it.mode         = MODE_READ;
    it.x            = COORD_W'($urandom_range(0, (1 << COORD_W) - 1));
    it.y            = COORD_W'($urandom_range(0, (1 << COORD_W) - 1));
    it.color        = COLOR_W'($urandom_range(0, (1 << COLOR_W) - 1));
    it.read_plane   = plane;
    it.read_address = addr[RADDR_W-1:0];
    return it;
  endfunction

  function automatic logic [COLOR_W-1:0] pick_colour();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return shadow_cfg.red_code;
    if (r < 7) return shadow_cfg.black_code;
    return COLOR_W'($urandom_range(0, (1 << COLOR_W) - 1));
  endfunction

  // one input transaction, with an occasional gap before it
  task automatic send_item(input fb_item_t it);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      @(negedge clk);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_if.valid        <= 1'b1;
    in_if.mode         <= it.mode;
    in_if.x            <= it.x;
    in_if.y            <= it.y;
    in_if.color        <= it.color;
    in_if.read_plane   <= it.read_plane;
    in_if.read_address <= it.read_address;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    items_sent++;
    expected_bytes.push_back(plane_step(it));
  endtask

  // stop sending and let every outstanding result come back
  task automatic drain();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  function automatic logic [PDATA_W-1:0] shadow_value(input logic [REG_IDX_W-1:0] idx);
    case (idx)
      REG_LOGICAL_WIDTH:  return PDATA_W'(shadow_cfg.logical_width);
      REG_LOGICAL_HEIGHT: return PDATA_W'(shadow_cfg.logical_height);
      REG_PHYSICAL_WIDTH: return PDATA_W'(shadow_cfg.physical_width);
      REG_ROTATED:        return PDATA_W'(shadow_cfg.rotated);
      REG_RED_CODE:       return PDATA_W'(shadow_cfg.red_code);
      REG_BLACK_CODE:     return PDATA_W'(shadow_cfg.black_code);
      default:            return '0;
    endcase
  endfunction

  // register write, then read back
  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] val);
    logic [PDATA_W-1:0] got;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_LOGICAL_WIDTH:  shadow_cfg.logical_width  = val[SIZE_W-1:0];
      REG_LOGICAL_HEIGHT: shadow_cfg.logical_height = val[SIZE_W-1:0];
      REG_PHYSICAL_WIDTH: shadow_cfg.physical_width = val[SIZE_W-1:0];
      REG_ROTATED:        shadow_cfg.rotated        = val[0];
      REG_RED_CODE:       shadow_cfg.red_code       = val[COLOR_W-1:0];
      REG_BLACK_CODE:     shadow_cfg.black_code     = val[COLOR_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    psel    <= 1'b1;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    got = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== shadow_value(idx))
      report_mismatch($sformatf("register %0d read back %0h, expected %0h",
                                idx, got, shadow_value(idx)));
  endtask

  // write the eight pixels of one panel byte that the current mapping can reach
  task automatic fill_byte(input int unsigned base_col, input int unsigned row);
    int unsigned lim_x;
    int unsigned lim_y;
    int unsigned c;
    lim_x = clamp_limit(shadow_cfg.logical_width);
    lim_y = clamp_limit(shadow_cfg.logical_height);
    for (int b = 0; b < 8; b++) begin
      c = base_col + b;
      if (!shadow_cfg.rotated) begin
        if (c <= lim_x && row <= lim_y) send_item(make_write(c, row, pick_colour()));
      end else begin
        if (c <= lim_y && row <= lim_x) send_item(make_write(row, lim_y - c, pick_colour()));
      end
    end
  endtask

  task automatic fill_random_byte();
    int unsigned col;
    int unsigned row;
    panel_pos($urandom_range(0, clamp_limit(shadow_cfg.logical_width)),
              $urandom_range(0, clamp_limit(shadow_cfg.logical_height)), col, row);
    fill_byte(col & ~32'd7, row);
  endtask

  task automatic read_random_byte();
    int unsigned addr;
    addr = complete_bytes[$urandom_range(0, complete_bytes.size() - 1)];
    send_item(make_read(1'($urandom_range(0, 1)), addr));
  endtask

  function automatic int unsigned pick_size();
    case ($urandom_range(0, 5))
      0:       return 1;
      1:       return 1024;
      2:       return $urandom_range(1, 64);
      3:       return $urandom_range(1, 1024);
      default: return $urandom_range(8, 300);
    endcase
  endfunction

  function automatic logic [COLOR_W-1:0] pick_code();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return RST_RED_CODE;
      default: return COLOR_W'($urandom_range(0, (1 << COLOR_W) - 1));
    endcase
  endfunction

  // result checking
  always @(posedge clk) begin : result_check
    fb_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      results_seen++;
      if (expected_bytes.size() == 0) begin
        report_mismatch("result with no transaction outstanding");
      end else begin
        want = expected_bytes.pop_front();
        if (out_if.read_data !== want.read_data)
          report_mismatch($sformatf("read_data %0h, expected %0h",
                                    out_if.read_data, want.read_data));
        if (out_if.out_of_range !== want.out_of_range)
          report_mismatch($sformatf("out_of_range %0b, expected %0b",
                                    out_if.out_of_range, want.out_of_range));
      end
    end
  end

  // watchdog on cycles with no transaction on any port
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (psel && penable)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // result side back-pressure in bursts
  initial begin : result_backpressure
    int span;
    out_if.ready = 1'b0;
    forever begin
      if (!idle_on) begin
        @(negedge clk);
        out_if.ready <= 1'b1;
      end else begin
        span = $urandom_range(1, 24);
        @(negedge clk);
        out_if.ready <= 1'b1;
        repeat (span - 1) @(negedge clk);
        if ($urandom_range(0, 2) != 0) begin
          span = $urandom_range(1, 18);
          @(negedge clk);
          out_if.ready <= 1'b0;
          repeat (span - 1) @(negedge clk);
        end
      end
    end
  end

  // red, black and other colours on byte 0, read back from both planes, then a clamped write
  task automatic test_pixel_colours();
    logic [COLOR_W-1:0] colour;
    for (int b = 0; b < 8; b++) begin
      case (b % 3)
        0:       colour = shadow_cfg.red_code;
        1:       colour = shadow_cfg.black_code;
        default: colour = 16'h07E0;
      endcase
      send_item(make_write(b, 0, colour));
    end
    send_item(make_read(PLANE_BLACK, 0));
    send_item(make_read(PLANE_RED, 0));
    send_item(make_write(1023, 1023, shadow_cfg.red_code));
  endtask

  // widest panel so that writes run past the end of the store
  task automatic test_out_of_range();
    drain();
    reg_write(REG_LOGICAL_WIDTH, 1024);
    reg_write(REG_LOGICAL_HEIGHT, 1024);
    reg_write(REG_PHYSICAL_WIDTH, 1024);
    send_item(make_write(1023, 63, shadow_cfg.black_code));
    send_item(make_write(0, 64, shadow_cfg.red_code));
    send_item(make_write(1023, 1023, shadow_cfg.red_code));
  endtask

  // swapped and mirrored mapping back onto byte 0
  task automatic test_rotation();
    drain();
    reg_write(REG_LOGICAL_WIDTH, 176);
    reg_write(REG_LOGICAL_HEIGHT, 264);
    reg_write(REG_PHYSICAL_WIDTH, 176);
    reg_write(REG_ROTATED, 1);
    send_item(make_write(0, 263, shadow_cfg.red_code));
    send_item(make_write(0, 262, shadow_cfg.black_code));
    send_item(make_read(PLANE_RED, 0));
  endtask

  // same code for red and black, red wins
  task automatic test_matching_codes();
    drain();
    reg_write(REG_ROTATED, 0);
    reg_write(REG_RED_CODE, 32'h5A5A);
    reg_write(REG_BLACK_CODE, 32'h5A5A);
    send_item(make_write(0, 0, 16'h5A5A));
    send_item(make_write(1, 0, 16'h0000));
    send_item(make_read(PLANE_RED, 0));
    send_item(make_read(PLANE_BLACK, 0));
  endtask

  // zero logical size clamps every coordinate to 0
  task automatic test_zero_size();
    drain();
    reg_write(REG_BLACK_CODE, 32'h0000);
    reg_write(REG_LOGICAL_WIDTH, 0);
    reg_write(REG_LOGICAL_HEIGHT, 0);
    send_item(make_write(1023, 512, shadow_cfg.black_code));
    send_item(make_read(PLANE_BLACK, 0));
    drain();
    reg_write(REG_ROTATED, 1);
    send_item(make_write(5, 5, shadow_cfg.red_code));
    send_item(make_read(PLANE_RED, 0));
  endtask

  // random settings per phase with byte fills, reads and raw writes
  task automatic test_random_traffic();
    int stop_at;
    int phase_end;
    logic [COLOR_W-1:0] code;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      drain();
      reg_write(REG_LOGICAL_WIDTH, pick_size());
      reg_write(REG_LOGICAL_HEIGHT, pick_size());
      reg_write(REG_PHYSICAL_WIDTH, ($urandom_range(0, 15) == 0) ? 0 : pick_size());
      reg_write(REG_ROTATED, $urandom_range(0, 1));
      code = pick_code();
      reg_write(REG_RED_CODE, code);
      reg_write(REG_BLACK_CODE, ($urandom_range(0, 7) == 0) ? code : pick_code());
      phase_end = items_sent + $urandom_range(50, 110);
      while (items_sent < phase_end && items_sent < stop_at) begin
        if (items_sent >= stop_at - CALM_ITEMS) idle_on = 1'b0;
        case ($urandom_range(0, 9))
          0, 1, 2, 3: fill_random_byte();
          4, 5, 6: begin
            if (complete_bytes.size() != 0) read_random_byte();
            else fill_random_byte();
          end
          7: begin
            if (complete_bytes.size() != 0)
              repeat ($urandom_range(2, 6)) read_random_byte();
          end
          default: send_item(make_write($urandom_range(0, 1023), $urandom_range(0, 1023),
                                        pick_colour()));
        endcase
      end
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    idle_on            = 1'b1;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    in_if.valid        = 1'b0;
    in_if.mode         = MODE_WRITE;
    in_if.x            = '0;
    in_if.y            = '0;
    in_if.color        = '0;
    in_if.read_plane   = PLANE_BLACK;
    in_if.read_address = '0;
    shadow_cfg.logical_width  = RST_LOGICAL_WIDTH;
    shadow_cfg.logical_height = RST_LOGICAL_HEIGHT;
    shadow_cfg.physical_width = RST_PHYSICAL_WIDTH;
    shadow_cfg.rotated        = RST_ROTATED;
    shadow_cfg.red_code       = RST_RED_CODE;
    shadow_cfg.black_code     = RST_BLACK_CODE;
    for (int i = 0; i < PLANE_BYTES_DEF; i++) begin
      black_mem[i]   = '0;
      red_mem[i]     = '0;
      filled_bits[i] = '0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_pixel_colours();
    test_out_of_range();
    test_rotation();
    test_matching_codes();
    test_zero_size();
    test_random_traffic();

    drain();
    $display("run: %0d transactions sent (%0d reads, %0d writes past the store)",
             items_sent, reads_sent, oor_writes);
    $display("run: %0d results checked, %0d fully written bytes, %0d mismatches",
             results_seen, complete_bytes.size(), mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
